### src/pcse_pkg.sv
// Shared types, constants and helpers for the pixel color special effects block.
// No dependencies; every other file in src imports this package.
package pcse_pkg;

  localparam int unsigned ChanWidth  = 5;
  localparam int unsigned CoefWidth  = 5;
  localparam int unsigned MaskWidth  = 6;
  localparam int unsigned LayerWidth = 3;
  localparam int unsigned IndexWidth = 3;
  localparam int unsigned DataWidth  = 6;

  localparam logic [LayerWidth-1:0] LayerMax   = 3'd5;
  localparam logic [LayerWidth-1:0] LayerObj   = 3'd0;
  localparam logic [ChanWidth-1:0]  ChanMax    = 5'd31;
  localparam logic [CoefWidth-1:0]  CoefMax    = 5'd16;
  localparam logic [9:0]            BlendRound = 10'd8;
  localparam logic [8:0]            LiftRound  = 9'd8;
  localparam logic [8:0]            DimRound   = 9'd7;

  typedef enum logic [1:0] {
    EFFECT_NONE     = 2'd0,
    EFFECT_BLEND    = 2'd1,
    EFFECT_BRIGHTEN = 2'd2,
    EFFECT_DARKEN   = 2'd3
  } effect_t;

  // Configuration register indexes on the write port.
  localparam logic [IndexWidth-1:0] RegEffectMode  = 3'd0;
  localparam logic [IndexWidth-1:0] RegFirstMask   = 3'd1;
  localparam logic [IndexWidth-1:0] RegSecondMask  = 3'd2;
  localparam logic [IndexWidth-1:0] RegBlendCoefA  = 3'd3;
  localparam logic [IndexWidth-1:0] RegBlendCoefB  = 3'd4;
  localparam logic [IndexWidth-1:0] RegFadeCoef    = 3'd5;

  typedef struct packed {
    logic [ChanWidth-1:0] red;
    logic [ChanWidth-1:0] green;
    logic [ChanWidth-1:0] blue;
  } pixel_t;

  // Configuration as seen by the datapath; coefficients are already clamped.
  typedef struct packed {
    effect_t              mode;
    logic [MaskWidth-1:0] first_mask;
    logic [MaskWidth-1:0] second_mask;
    logic [CoefWidth-1:0] coef_a;
    logic [CoefWidth-1:0] coef_b;
    logic [CoefWidth-1:0] fade;
  } cfg_t;

  // Decision inputs for one pixel.
  typedef struct packed {
    logic [LayerWidth-1:0] top_layer;
    logic                  second_present;
    logic [LayerWidth-1:0] second_layer;
    logic                  effects_enabled;
    logic                  sprite_semi_transparent;
  } sel_in_t;

  function automatic logic [CoefWidth-1:0] clamp_coef(input logic [CoefWidth-1:0] c);
    clamp_coef = (c > CoefMax) ? CoefMax : c;
  endfunction

endpackage

### src/pcse_cfg_regs.sv
// Configuration registers of the color effects block, with coefficient clamping.
// Depends on pcse_pkg.
module pcse_cfg_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           write_enable,
  input  logic [pcse_pkg::IndexWidth-1:0] write_index,
  input  logic [pcse_pkg::DataWidth-1:0]  write_data,
  output pcse_pkg::cfg_t                  cfg
);
  import pcse_pkg::*;

  logic [1:0]           effect_mode;
  logic [MaskWidth-1:0] first_target_mask;
  logic [MaskWidth-1:0] second_target_mask;
  logic [CoefWidth-1:0] blend_coef_a;
  logic [CoefWidth-1:0] blend_coef_b;
  logic [CoefWidth-1:0] fade_coef;

  always_ff @(posedge clk) begin
    if (rst) begin
      effect_mode        <= '0;
      first_target_mask  <= '0;
      second_target_mask <= '0;
      blend_coef_a       <= '0;
      blend_coef_b       <= '0;
      fade_coef          <= '0;
    end else if (write_enable) begin
      case (write_index)
        RegEffectMode: effect_mode        <= write_data[1:0];
        RegFirstMask:  first_target_mask  <= write_data[MaskWidth-1:0];
        RegSecondMask: second_target_mask <= write_data[MaskWidth-1:0];
        RegBlendCoefA: blend_coef_a       <= write_data[CoefWidth-1:0];
        RegBlendCoefB: blend_coef_b       <= write_data[CoefWidth-1:0];
        RegFadeCoef:   fade_coef          <= write_data[CoefWidth-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    cfg.mode        = effect_t'(effect_mode);
    cfg.first_mask  = first_target_mask;
    cfg.second_mask = second_target_mask;
    cfg.coef_a      = clamp_coef(blend_coef_a);
    cfg.coef_b      = clamp_coef(blend_coef_b);
    cfg.fade        = clamp_coef(fade_coef);
  end

endmodule

### src/pcse_effect_sel.sv
// Chooses which effect applies to one pixel from layer ids, masks and mode.
// Depends on pcse_pkg.
module pcse_effect_sel (
  input  pcse_pkg::sel_in_t sel,
  input  pcse_pkg::cfg_t    cfg,
  output pcse_pkg::effect_t effect
);
  import pcse_pkg::*;

  logic first_ok;
  logic second_ok;
  logic forced;

  always_comb begin
    first_ok  = (sel.top_layer inside {[LayerObj:LayerMax]}) &&
                cfg.first_mask[sel.top_layer];
    second_ok = (sel.second_layer inside {[LayerObj:LayerMax]}) &&
                cfg.second_mask[sel.second_layer];
    // A semi-transparent sprite over a second target blends even when the
    // window turns effects off.
    forced = sel.sprite_semi_transparent && (sel.top_layer == LayerObj) && second_ok;

    effect = EFFECT_NONE;
    if (sel.second_present && (forced || sel.effects_enabled)) begin
      if (forced || (cfg.mode == EFFECT_BLEND && first_ok && second_ok)) begin
        effect = EFFECT_BLEND;
      end else if (cfg.mode == EFFECT_BRIGHTEN && first_ok) begin
        effect = EFFECT_BRIGHTEN;
      end else if (cfg.mode == EFFECT_DARKEN && first_ok) begin
        effect = EFFECT_DARKEN;
      end
    end
  end

endmodule

### src/pcse_channel.sv
// Blend, brighten and darken arithmetic for one 5-bit color channel.
// Depends on pcse_pkg.
module pcse_channel (
  input  logic [pcse_pkg::ChanWidth-1:0] top,
  input  logic [pcse_pkg::ChanWidth-1:0] second,
  input  pcse_pkg::effect_t              effect,
  input  pcse_pkg::cfg_t                 cfg,
  output logic [pcse_pkg::ChanWidth-1:0] result
);
  import pcse_pkg::*;

  logic [9:0]           mix_sum;
  logic [5:0]           mix_val;
  logic [ChanWidth-1:0] mix;
  logic [ChanWidth-1:0] headroom;
  logic [8:0]           lift_sum;
  logic [8:0]           dim_sum;

  always_comb begin
    mix_sum  = {5'b0, top} * {5'b0, cfg.coef_a} + {5'b0, second} * {5'b0, cfg.coef_b}
               + BlendRound;
    mix_val  = mix_sum[9:4];
    mix      = (mix_val > {1'b0, ChanMax}) ? ChanMax : mix_val[ChanWidth-1:0];

    headroom = ChanMax - top;
    lift_sum = {4'b0, headroom} * {4'b0, cfg.fade} + LiftRound;
    dim_sum  = {4'b0, top} * {4'b0, cfg.fade} + DimRound;

    case (effect)
      EFFECT_NONE:     result = top;
      EFFECT_BLEND:    result = mix;
      // The step never exceeds the headroom, so the sum stays within 5 bits.
      EFFECT_BRIGHTEN: result = top + lift_sum[8:4];
      EFFECT_DARKEN:   result = top - dim_sum[8:4];
      default:         result = top;
    endcase
  end

endmodule

### src/pixel_color_special_effects.sv
// Top level of the pixel color special effects block: input register, effect
// selection and channel arithmetic, result register. Depends on pcse_pkg,
// pcse_cfg_regs, pcse_effect_sel and pcse_channel.
//
//   Channel   Handshake                 Payload
//   input     start, busy               top_*, second_*, effects_enabled, sprite_...
//   result    done (one-cycle strobe)   out_red, out_green, out_blue, applied_effect
//   config    write_enable              write_index, write_data
//
// A transferred pixel passes from the input register through the effect logic
// to the result register, where done marks it for exactly one cycle.
// One pixel can be taken every cycle outside reset: the input register and the result
// register bound a single pass of effect logic.
// Reset is synchronous and clears the valid flags and configuration; busy is
// high only while rst is held. The receiver cannot stall the block.
module pixel_color_special_effects (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [pcse_pkg::LayerWidth-1:0] top_layer,
  input  logic [pcse_pkg::ChanWidth-1:0]  top_red,
  input  logic [pcse_pkg::ChanWidth-1:0]  top_green,
  input  logic [pcse_pkg::ChanWidth-1:0]  top_blue,
  input  logic                            second_present,
  input  logic [pcse_pkg::LayerWidth-1:0] second_layer,
  input  logic [pcse_pkg::ChanWidth-1:0]  second_red,
  input  logic [pcse_pkg::ChanWidth-1:0]  second_green,
  input  logic [pcse_pkg::ChanWidth-1:0]  second_blue,
  input  logic                            effects_enabled,
  input  logic                            sprite_semi_transparent,
  input  logic                            write_enable,
  input  logic [pcse_pkg::IndexWidth-1:0] write_index,
  input  logic [pcse_pkg::DataWidth-1:0]  write_data,
  output logic                            done,
  output logic [pcse_pkg::ChanWidth-1:0]  out_red,
  output logic [pcse_pkg::ChanWidth-1:0]  out_green,
  output logic [pcse_pkg::ChanWidth-1:0]  out_blue,
  output logic [1:0]                      applied_effect
);
  import pcse_pkg::*;

  cfg_t    cfg;
  logic    accept;
  logic    in_valid;
  sel_in_t in_sel;
  pixel_t  in_top;
  pixel_t  in_second;
  effect_t effect;
  pixel_t  result_next;

  assign busy   = rst;
  assign accept = start && !busy;

  pcse_cfg_regs u_cfg_regs (
    .clk          (clk),
    .rst          (rst),
    .write_enable (write_enable),
    .write_index  (write_index),
    .write_data   (write_data),
    .cfg          (cfg)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_sel.top_layer               <= top_layer;
      in_sel.second_present          <= second_present;
      in_sel.second_layer            <= second_layer;
      in_sel.effects_enabled         <= effects_enabled;
      in_sel.sprite_semi_transparent <= sprite_semi_transparent;
      in_top    <= '{red: top_red, green: top_green, blue: top_blue};
      in_second <= '{red: second_red, green: second_green, blue: second_blue};
    end
  end

  pcse_effect_sel u_effect_sel (
    .sel    (in_sel),
    .cfg    (cfg),
    .effect (effect)
  );

  pcse_channel u_chan_red (
    .top    (in_top.red),
    .second (in_second.red),
    .effect (effect),
    .cfg    (cfg),
    .result (result_next.red)
  );

  pcse_channel u_chan_green (
    .top    (in_top.green),
    .second (in_second.green),
    .effect (effect),
    .cfg    (cfg),
    .result (result_next.green)
  );

  pcse_channel u_chan_blue (
    .top    (in_top.blue),
    .second (in_second.blue),
    .effect (effect),
    .cfg    (cfg),
    .result (result_next.blue)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      out_red        <= result_next.red;
      out_green      <= result_next.green;
      out_blue       <= result_next.blue;
      applied_effect <= effect;
    end
  end

`ifndef SYNTH
  // Every result strobe traces back to a transfer through the input and result registers.
  a_done_follows_transfer: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, 2))
    else $error("result strobe without a matching input transfer");

  // Without a second layer no effect can apply.
  a_no_second_no_effect: assert property (@(posedge clk) disable iff (rst)
    (done && !$past(second_present, 2)) |-> (applied_effect == EFFECT_NONE))
    else $error("effect applied with no second layer");

  // When no effect applies the top pixel passes through unchanged.
  a_pass_through: assert property (@(posedge clk) disable iff (rst)
    (done && applied_effect == EFFECT_NONE) |->
      (out_red == $past(top_red, 2) && out_green == $past(top_green, 2) &&
       out_blue == $past(top_blue, 2)))
    else $error("pass-through pixel altered");
`endif

endmodule
